// File: design/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared constants and types for the TLB page-table translator
// Sizes of the TLB, the page map and the frame space, and the address split.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int FRAME_W  = $clog2(FRAME_COUNT);

    typedef logic [PAGE_W-1:0]      t_page;
    typedef logic [FRAME_W-1:0]     t_frame;
    typedef logic [TLB_IDX_W-1:0]   t_tlb_idx;
    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [TOTAL_W-1:0]     t_total;

endpackage : tpt_pkg

`default_nettype wire

// File: design/tpt_stream_if.sv
// ----------------------------------------------------------------------------
// tpt stream interfaces
// Valid/ready channels for address beats in and translation beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);
endinterface : tpt_in_if

interface tpt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        map_fault;
    logic [31:0] hits_so_far;
    logic [31:0] faults_so_far;

    modport source (output valid, output physical_address, output tlb_hit,
                    output map_fault, output hits_so_far, output faults_so_far,
                    input ready);
    modport sink   (input valid, input physical_address, input tlb_hit,
                    input map_fault, input hits_so_far, input faults_so_far,
                    output ready);
endinterface : tpt_out_if

`default_nettype wire

// File: design/tlb_page_table_translator.sv
// An accepted address beat is registered in r_va, with its page-map read in
// r_map_q; resolve writes its translation to the output register. Ready is
// high only in idle, so a new address waits until the last one is resolved.
// Resolve is held only while the output register holds a beat not yet taken.
// Reset clears the TLB and page-map valid bits, the FIFO pointer, the frame
// allocator and both totals; the page-map frames themselves are not cleared.
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Translates virtual addresses through a 16-slot FIFO-replaced TLB backed by
// a 256-entry page map with sequential frame allocation on a fault.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator
    import tpt_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    tpt_in_if.sink     i_in,
    tpt_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RESOLVE = 2'b10
    } t_state;

    t_state r_state, n_state;

    // TLB in flip-flops, searched in parallel
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    t_page                  r_tlb_tag   [TLB_ENTRIES];
    t_frame                 r_tlb_frame [TLB_ENTRIES];
    t_tlb_idx               r_fifo_slot;

    // Page map: frames in a synchronous memory, valid bits in flip-flops
    t_frame                 map_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0]  r_map_valid;
    t_frame                 r_map_q;

    t_frame   r_next_frame;
    t_total   r_hit_total;
    t_total   r_fault_total;

    logic [ADDR_W-1:0] r_va;

    // Output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_pa;
    logic              r_out_hit;
    logic              r_out_fault;
    t_total            r_out_hits;
    t_total            r_out_faults;

    logic     in_acc;
    logic     finish;
    t_page    in_page;
    t_page    cur_page;
    t_offset  cur_offset;
    logic     hit;
    t_frame   hit_frame;
    logic     fault;
    t_frame   frame;
    t_total   n_hit_total;
    t_total   n_fault_total;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign in_page    = i_in.virtual_address[OFFSET_BITS +: PAGE_W];
    assign cur_page   = r_va[OFFSET_BITS +: PAGE_W];
    assign cur_offset = r_va[OFFSET_BITS-1:0];

    // Lowest matching slot wins.
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_tag[i] == cur_page)) begin
                hit       = 1'b1;
                hit_frame = r_tlb_frame[i];
            end
        end
    end

    always_comb begin
        fault = !hit && !r_map_valid[cur_page];
        if (hit) begin
            frame = hit_frame;
        end else if (fault) begin
            frame = r_next_frame;
        end else begin
            frame = r_map_q;
        end
        n_hit_total   = (hit && (r_hit_total != '1)) ? r_hit_total + 1'b1 : r_hit_total;
        n_fault_total = (fault && (r_fault_total != '1)) ?
                        r_fault_total + 1'b1 : r_fault_total;
    end

    assign finish = (r_state == S_RESOLVE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (finish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The map read is taken only on an accepted beat, so it holds during a stall.
    always_ff @(posedge i_clk) begin
        if (finish && fault) begin
            map_mem[cur_page] <= r_next_frame;
        end
        if (in_acc) begin
            r_map_q <= map_mem[in_page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_va <= i_in.virtual_address;
        end
        if (finish && !hit) begin
            r_tlb_tag[r_fifo_slot]   <= cur_page;
            r_tlb_frame[r_fifo_slot] <= frame;
        end
        if (finish) begin
            r_out_pa     <= {frame, cur_offset};
            r_out_hit    <= hit;
            r_out_fault  <= fault;
            r_out_hits   <= n_hit_total;
            r_out_faults <= n_fault_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tlb_valid   <= '0;
            r_map_valid   <= '0;
            r_fifo_slot   <= '0;
            r_next_frame  <= '0;
            r_hit_total   <= '0;
            r_fault_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_hit_total   <= n_hit_total;
                r_fault_total <= n_fault_total;
                if (!hit) begin
                    r_tlb_valid[r_fifo_slot] <= 1'b1;
                    if (r_fifo_slot == t_tlb_idx'(TLB_ENTRIES - 1)) begin
                        r_fifo_slot <= '0;
                    end else begin
                        r_fifo_slot <= r_fifo_slot + 1'b1;
                    end
                end
                if (fault) begin
                    r_map_valid[cur_page] <= 1'b1;
                    if (r_next_frame == t_frame'(FRAME_COUNT - 1)) begin
                        r_next_frame <= '0;
                    end else begin
                        r_next_frame <= r_next_frame + 1'b1;
                    end
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.physical_address = r_out_pa;
    assign o_out.tlb_hit          = r_out_hit;
    assign o_out.map_fault        = r_out_fault;
    assign o_out.hits_so_far      = r_out_hits;
    assign o_out.faults_so_far    = r_out_faults;

endmodule : tlb_page_table_translator

`default_nettype wire

// File: design/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker: port-level assertions for the translator
// Watches the address and translation channels and checks their relation.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_hit,
    input wire        i_out_fault,
    input wire [31:0] i_out_hits,
    input wire [31:0] i_out_faults
);

    // A waiting translation beat stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("translation beat dropped before it was taken");

    // Only one address is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("address accepted while another was in flight");

    a_hit_xor_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_hit && i_out_fault))
        else $error("a beat reports both a TLB hit and a page fault");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_hit |-> (i_out_hits != 32'd0))
        else $error("TLB hit reported with a zero hit total");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_fault |-> (i_out_faults != 32'd0))
        else $error("page fault reported with a zero fault total");

endmodule : tpt_checker

bind tlb_page_table_translator tpt_checker u_tpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_hit    (o_out.tlb_hit),
    .i_out_fault  (o_out.map_fault),
    .i_out_hits   (o_out.hits_so_far),
    .i_out_faults (o_out.faults_so_far)
);

`default_nettype wire
